// ===== sv/fal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault aggregator package
// Shared types and constants for the fault aggregator and latch block.
// ----------------------------------------------------------------------------
package fal_pkg;

    localparam int MASK_W      = 16;
    localparam int COUNT_W     = 5;
    localparam int HOLD_W      = 10;
    localparam int INDEX_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int LIMIT_W     = 7;

    localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 10'd50;

    typedef enum logic [1:0] {
        REQ_TRIGGER = 2'd0,
        REQ_CLEAR   = 2'd1,
        REQ_POLL    = 2'd2,
        REQ_RESET   = 2'd3
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAULT_COUNT     = 2'd0,
        CFG_PERMANENT_MASK  = 2'd1,
        CFG_RESETTABLE_MASK = 2'd2,
        CFG_CLEAR_HOLD      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [COUNT_W-1:0] fault_count;
        logic [MASK_W-1:0]  permanent_mask;
        logic [MASK_W-1:0]  resettable_mask;
        logic [HOLD_W-1:0]  clear_hold_ticks;
    } cfg_t;

    // Bit 0 is the resettable line, bit 1 the non-resettable line.
    typedef struct packed {
        req_type_t          req_type;
        logic [INDEX_W-1:0] fault_index;
        logic [1:0]         sample;
    } req_t;

    typedef struct packed {
        logic resettable_out;
        logic nonresettable_out;
        logic clearing_active;
        logic clear_refused;
        logic index_error;
    } result_t;

endpackage

// ===== sv/fal_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault aggregator configuration registers
// Holds slot count, the two per-slot masks and the hold window length.
// ----------------------------------------------------------------------------
module fal_regs
    import fal_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FAULT_COUNT:     cfg_next.fault_count      = cfg_data[COUNT_W-1:0];
                CFG_PERMANENT_MASK:  cfg_next.permanent_mask   = cfg_data[MASK_W-1:0];
                CFG_RESETTABLE_MASK: cfg_next.resettable_mask  = cfg_data[MASK_W-1:0];
                CFG_CLEAR_HOLD:      cfg_next.clear_hold_ticks = cfg_data[HOLD_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fault_count      <= '0;
            cfg_reg.permanent_mask   <= '0;
            cfg_reg.resettable_mask  <= '0;
            cfg_reg.clear_hold_ticks <= HOLD_TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/fal_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault aggregator core
// Updates the fault flags, signal edges, latches and hold window for one
// registered request per cycle and registers the result.
// ----------------------------------------------------------------------------
module fal_core
    import fal_pkg::*;
#(
    parameter int NUM_FAULTS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    req_valid,
    input  req_t    req,
    output logic    res_valid,
    output result_t res
);

    logic [NUM_FAULTS-1:0] flags_reg, flags_next;
    logic [1:0]            line_reg, line_next;
    logic [1:0]            table_reg, table_next;
    logic                  r_latch_reg, r_latch_next;
    logic                  n_latch_reg, n_latch_next;
    logic                  clearing_reg, clearing_next;
    logic [HOLD_W-1:0]     hold_reg, hold_next;
    logic                  done_reg;
    result_t               res_reg, res_next;

    logic [LIMIT_W-1:0]    limit;
    logic [NUM_FAULTS-1:0] valid_slots;
    logic [NUM_FAULTS-1:0] perm_ext;
    logic [NUM_FAULTS-1:0] res_ext;
    logic [NUM_FAULTS-1:0] active;
    logic [1:0]            rising;
    logic                  idx_ok;
    logic                  refused;
    logic                  cleared;
    logic                  recompute;

    always_comb
    begin
        // Slot count saturates at the number of slots that exist.
        if ({2'b00, cfg.fault_count} > LIMIT_W'(NUM_FAULTS))
            limit = LIMIT_W'(NUM_FAULTS);
        else
            limit = {2'b00, cfg.fault_count};

        for (int i = 0; i < NUM_FAULTS; i++)
        begin
            valid_slots[i] = (LIMIT_W'(i) < limit);
            if (i < MASK_W)
            begin
                perm_ext[i] = cfg.permanent_mask[i[INDEX_W-1:0]];
                res_ext[i]  = cfg.resettable_mask[i[INDEX_W-1:0]];
            end
            else
            begin
                perm_ext[i] = 1'b0;
                res_ext[i]  = 1'b0;
            end
        end

        idx_ok  = ({3'b000, req.fault_index} < limit);
        refused = 1'b0;
        cleared = 1'b0;
        recompute = 1'b0;

        flags_next    = flags_reg;
        line_next     = line_reg;
        table_next    = table_reg;
        clearing_next = clearing_reg;
        hold_next     = hold_reg;

        case (req.req_type)
            REQ_TRIGGER:
            begin
                if (idx_ok)
                begin
                    flags_next = flags_reg | (NUM_FAULTS'(1) << req.fault_index);
                    recompute  = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                if (idx_ok)
                begin
                    flags_next = flags_reg & ~(NUM_FAULTS'(1) << req.fault_index);
                    recompute  = 1'b1;
                end
            end
            REQ_POLL:
            begin
                if (clearing_reg)
                begin
                    if (hold_reg <= HOLD_W'(1))
                    begin
                        hold_next     = '0;
                        clearing_next = 1'b0;
                    end
                    else
                    begin
                        hold_next = hold_reg - HOLD_W'(1);
                    end
                end
                else
                begin
                    line_next = req.sample;
                end
            end
            REQ_RESET:
            begin
                if ((|(flags_reg & valid_slots & perm_ext)) || line_reg[1])
                begin
                    refused = 1'b1;
                end
                else
                begin
                    cleared       = 1'b1;
                    recompute     = 1'b1;
                    clearing_next = 1'b1;
                    flags_next    = flags_reg & ~(valid_slots & ~perm_ext);
                    hold_next     = cfg.clear_hold_ticks;
                end
            end
            default:
            begin
                flags_next = flags_reg;
            end
        endcase

        active = flags_next & valid_slots;
        if (recompute)
            table_next = {|(active & ~res_ext), |(active & res_ext)};

        // An unchanged signal pair gives no edge, so the edge test can run always.
        rising       = (line_next | table_next) & ~(line_reg | table_reg);
        r_latch_next = (r_latch_reg | rising[0]) & ~cleared;
        n_latch_next = n_latch_reg | rising[1];

        res_next.resettable_out    = r_latch_next;
        res_next.nonresettable_out = n_latch_next;
        res_next.clearing_active   = clearing_next;
        res_next.clear_refused     = refused;
        res_next.index_error       = ((req.req_type == REQ_TRIGGER) ||
                                      (req.req_type == REQ_CLEAR)) && !idx_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg    <= '0;
            line_reg     <= '0;
            table_reg    <= '0;
            r_latch_reg  <= 1'b0;
            n_latch_reg  <= 1'b0;
            clearing_reg <= 1'b0;
            hold_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid;
            if (req_valid)
            begin
                flags_reg    <= flags_next;
                line_reg     <= line_next;
                table_reg    <= table_next;
                r_latch_reg  <= r_latch_next;
                n_latch_reg  <= n_latch_next;
                clearing_reg <= clearing_next;
                hold_reg     <= hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid)
            res_reg <= res_next;
    end

    assign res_valid = done_reg;
    assign res       = res_reg;

    // The hold counter only runs inside the hold window.
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !clearing_reg |-> (hold_reg == '0))
        else $error("hold counter nonzero outside hold window");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(res_reg.clear_refused && res_reg.index_error))
        else $error("refusal and index error on the same beat");

    a_refuse_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.clear_refused) |-> (flags_reg == $past(flags_reg)))
        else $error("refused reset request changed fault flags");

    a_nres_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(n_latch_reg))
        else $error("non-resettable output dropped");

endmodule

// ===== sv/fault_aggregator_latch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault aggregator and latch
// Collects triggered faults and external fault lines into latched
// resettable and non-resettable outputs, with reset requests and a hold window.
// ----------------------------------------------------------------------------
// A request is captured in the request beat register, and the core then
// registers its result, which appears on the outputs with done high.
// Throughput: one request per cycle while busy is low. Results cannot be
// stalled by the receiver.
// Reset: core state and latches clear and the configuration returns to its
// defaults, but the result register is not reset; busy stays high until the
// first clock edge after reset is released.
module fault_aggregator_latch
    import fal_pkg::*;
#(
    parameter int NUM_FAULTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            req_type,
    input  logic [INDEX_W-1:0]    fault_index,
    input  logic                  resettable_line_low,
    input  logic                  nonresettable_line_low,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic                  resettable_out,
    output logic                  nonresettable_out,
    output logic                  clearing_active,
    output logic                  clear_refused,
    output logic                  index_error
);

    logic    busy_reg;
    logic    in_valid_reg;
    req_t    in_reg;
    cfg_t    cfg;
    result_t res;
    logic    accept;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= 1'b0;
            in_valid_reg <= accept;
        end
    end

    // Request beat register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg.req_type    <= req_type_t'(req_type);
            in_reg.fault_index <= fault_index;
            in_reg.sample      <= {nonresettable_line_low, resettable_line_low};
        end
    end

    fal_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fal_core #(
        .NUM_FAULTS (NUM_FAULTS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (in_valid_reg),
        .req       (in_reg),
        .res_valid (done),
        .res       (res)
    );

    assign resettable_out    = res.resettable_out;
    assign nonresettable_out = res.nonresettable_out;
    assign clearing_active   = res.clearing_active;
    assign clear_refused     = res.clear_refused;
    assign index_error       = res.index_error;

endmodule
